### rtl/core/pwm_encoder_angle_tracker_unit_macros.svh
// Assertion helpers for the encoder angle tracker.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef PWM_ENCODER_ANGLE_TRACKER_UNIT_MACROS_SVH
`define PWM_ENCODER_ANGLE_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTH
`define PWMENC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PWMENC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PWMENC_ASSERT(label, prop, msg)
`define PWMENC_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/core/pwmenc_pkg.sv
`default_nettype none

package pwmenc_pkg;

  // Request kinds on the input stream
  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_OVF    = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_LOW    = 2'd1;
  localparam logic [1:0] CFG_HIGH   = 2'd2;

  localparam int TS_W     = 16;
  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 10;
  localparam int TALLY_W  = 16;
  localparam int ANGLE_W  = 16;
  localparam int TURN_W   = 16;
  localparam int CFG_W    = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1100;
  localparam logic [DUTY_W-1:0]   LOW_RST    = 10'd29;
  localparam logic [DUTY_W-1:0]   HIGH_RST   = 10'd971;
  localparam logic [TURN_W-1:0]   TURN_RST   = 16'hFFFF;
  localparam logic [TURN_W-1:0]   TURN_MIN   = 16'h8000;
  localparam logic [TURN_W-1:0]   TURN_MAX   = 16'h7FFF;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic load_width;
    logic load_prod;
    logic load_mag;
    logic load_num;
    logic div_step;
    logic commit;
    logic reject;
    logic load_out;
  } pwmenc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic long_op;
    logic in_range;
    logic div_done;
  } pwmenc_sts_t;

endpackage

`default_nettype wire

### rtl/core/pwmenc_ctrl.sv
`default_nettype none

module pwmenc_ctrl import pwmenc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire pwmenc_sts_t sts_i,
  output pwmenc_cmd_t      cmd_o,
  output logic             busy_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WIDTH = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_MAG   = 3'd3;
  localparam logic [2:0] ST_NUM   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_REJ   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.take = 1'b1;
          if (sts_i.long_op) begin
            state_d = ST_WIDTH;
          end else begin
            cmd_o.load_out = 1'b1;
          end
        end
      end
      ST_WIDTH: begin
        cmd_o.load_width = 1'b1;
        state_d          = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.in_range) begin
          cmd_o.load_prod = 1'b1;
          state_d         = ST_MAG;
        end else begin
          state_d = ST_REJ;
        end
      end
      ST_MAG: begin
        cmd_o.load_mag = 1'b1;
        state_d        = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.load_num = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.commit   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (out_free) begin
          cmd_o.reject   = 1'b1;
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign busy_o      = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/pwmenc_dp.sv
`default_nettype none

module pwmenc_dp import pwmenc_pkg::*; #(
  parameter int TIMER_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i,
  input  wire logic [1:0]          kind_i,
  input  wire logic [TS_W-1:0]     ts_i,
  input  wire pwmenc_cmd_t         cmd_i,
  output pwmenc_sts_t              sts_o,
  output logic [ANGLE_W-1:0]       out_angle_o,
  output logic [TURN_W-1:0]        out_turns_o,
  output logic                     out_updated_o,
  output logic                     out_rejected_o
);

  localparam int TB      = TIMER_BITS;
  localparam int F       = ANGLE_FRAC_BITS;
  localparam int WIDTH_W = TB + 18;
  localparam int PROD_W  = 26;
  localparam int MAG_W   = 26;
  localparam int DEN_W   = 27;
  localparam int NUM_W   = 36 + F;
  localparam int AW      = NUM_W + 2;
  localparam int CNT_W   = $clog2(NUM_W + 1);
  localparam int AngleRstInt = ((180 << F) > 32767) ? 32767 : (180 << F);
  localparam logic [ANGLE_W-1:0] ANGLE_RST = ANGLE_W'(AngleRstInt);
  localparam logic signed [AW-1:0] ANGLE_BASE = AW'(359 << F);
  localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
  localparam logic signed [AW-1:0] SAT_MIN = AW'(-32768);
  localparam logic signed [31:0] JUMP_THR = 32'(180 << F);

  // Configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [DUTY_W-1:0]   low_q, high_q;

  // Capture state
  logic                awaiting_q, ready_q;
  logic [TB-1:0]       rise_q, fall_q;
  logic [TALLY_W-1:0]  tally_q;
  logic [ANGLE_W-1:0]  angle_q, angle_d;
  logic [TURN_W-1:0]   turn_q, turn_d;

  // Arithmetic pipeline
  logic signed [WIDTH_W-1:0] width_q, width_d;
  logic [PROD_W-1:0]   p1_q, p2_q;
  logic [DEN_W-1:0]    den_q, den_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic                neg_q;
  logic [NUM_W-1:0]    dvd_q;
  logic [DEN_W-1:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;

  logic [TB+TS_W-1:0]  ts_wide;
  logic [TB-1:0]       ts_t, sdiff;
  logic [PERIOD_W-1:0] period_eff;
  logic signed [11:0]  d_raw;
  logic [10:0]         d_eff;
  logic signed [26:0]  diff;
  logic [26:0]         diff_abs;
  logic [34:0]         prod;
  logic [NUM_W-1:0]    dvd_d;
  logic [DEN_W:0]      trial;
  logic                qbit;
  logic [DEN_W-1:0]    rem_next;
  logic signed [AW-1:0] q_s, a_full;
  logic [ANGLE_W-1:0]  a_new;
  logic signed [31:0]  jump;

  assign ts_wide    = {{TB{1'b0}}, ts_i};
  assign ts_t       = ts_wide[TB-1:0];
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign d_raw      = $signed({2'b00, high_q}) - $signed({2'b00, low_q}) + 12'sd10;
  assign d_eff      = (d_raw < 12'sd1) ? 11'd1 : d_raw[10:0];

  // Signed timestamp difference plus whole timer wraps
  assign sdiff   = fall_q - rise_q;
  assign width_d = $signed({{18{sdiff[TB-1]}}, sdiff})
                 + $signed({2'b00, tally_q, {TB{1'b0}}});

  assign den_d    = period_eff * d_eff;
  assign diff     = $signed({1'b0, p1_q}) - $signed({1'b0, p2_q});
  assign diff_abs = diff[26] ? (27'd0 - diff) : diff;
  assign mag_d    = diff_abs[MAG_W-1:0];
  assign prod     = mag_q * 9'd360;
  // Bias by half the divisor so the truncating divide rounds to nearest
  assign dvd_d    = (NUM_W'(prod) << F) + NUM_W'(den_q >> 1);

  // One restoring division step
  assign trial    = {rem_q, dvd_q[NUM_W-1]};
  assign qbit     = (trial >= {1'b0, den_q});
  assign rem_next = qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

  // Final angle with saturation, then the wrap check against the old angle
  assign q_s    = neg_q ? -$signed({2'b00, dvd_q}) : $signed({2'b00, dvd_q});
  assign a_full = ANGLE_BASE - q_s;
  assign a_new  = (a_full > SAT_MAX) ? ANGLE_W'(SAT_MAX) :
                  (a_full < SAT_MIN) ? ANGLE_W'(SAT_MIN) : a_full[ANGLE_W-1:0];
  assign jump   = $signed({{16{a_new[15]}}, a_new}) - $signed({{16{angle_q[15]}}, angle_q});

  always_comb begin
    angle_d = angle_q;
    turn_d  = turn_q;
    if (cmd_i.commit) begin
      angle_d = a_new;
      if (jump > JUMP_THR) begin
        if (turn_q != TURN_MIN) turn_d = turn_q - 1'b1;
      end else if (jump < -JUMP_THR) begin
        if (turn_q != TURN_MAX) turn_d = turn_q + 1'b1;
      end
    end
  end

  assign sts_o.long_op  = (kind_i == KIND_UPDATE) && ready_q;
  assign sts_o.in_range = (width_q[WIDTH_W-1:16] == '0) && (width_q[15:0] <= period_eff);
  assign sts_o.div_done = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RST;
      low_q      <= LOW_RST;
      high_q     <= HIGH_RST;
      awaiting_q <= 1'b0;
      ready_q    <= 1'b0;
      rise_q     <= '0;
      fall_q     <= '0;
      tally_q    <= '0;
      angle_q    <= ANGLE_RST;
      turn_q     <= TURN_RST;
      cnt_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_LOW:    low_q    <= cfg_data_i[DUTY_W-1:0];
          CFG_HIGH:   high_q   <= cfg_data_i[DUTY_W-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.take) begin
        unique case (kind_i)
          KIND_EDGE: begin
            if (!awaiting_q && !ready_q) begin
              rise_q     <= ts_t;
              tally_q    <= '0;
              awaiting_q <= 1'b1;
            end else if (awaiting_q && !ready_q) begin
              fall_q     <= ts_t;
              awaiting_q <= 1'b0;
              ready_q    <= 1'b1;
            end
          end
          KIND_OVF: begin
            if (awaiting_q && !ready_q && (tally_q != '1)) tally_q <= tally_q + 1'b1;
          end
          KIND_UPDATE: ready_q <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.load_num) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      angle_q <= angle_d;
      turn_q  <= turn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_width) width_q <= width_d;
    if (cmd_i.load_prod) begin
      p1_q  <= width_q[15:0] * 10'd1000;
      p2_q  <= low_q * period_eff;
      den_q <= den_d;
    end
    if (cmd_i.load_mag) begin
      mag_q <= mag_d;
      neg_q <= diff[26];
    end
    if (cmd_i.load_num) begin
      dvd_q <= dvd_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NUM_W-2:0], qbit};
      rem_q <= rem_next;
    end
    if (cmd_i.load_out) begin
      out_angle_o    <= angle_d;
      out_turns_o    <= turn_d;
      out_updated_o  <= cmd_i.commit;
      out_rejected_o <= cmd_i.reject;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pwm_encoder_angle_tracker_unit.sv
// Edge, overflow and idle update requests: result valid in the cycle after accept.
// Update with a finished capture: width, range check, products, magnitude, numerator,
// then the one-bit-per-cycle restoring divider, then the result; out-of-range widths
// go from the range check to a rejection. One request in flight at a time; a request is
// taken when the result slot is free. Reset (async, active low): registers to 1100/29/971,
// capture idle, angle 180 deg, turns -1, output stream empty.
`default_nettype none
`include "pwm_encoder_angle_tracker_unit_macros.svh"

module pwm_encoder_angle_tracker_unit import pwmenc_pkg::*; #(
  parameter int TIMER_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  // Request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [15:0] timestamp
  input  wire logic [1:0]        s_axis_tuser,   // [1:0] kind
  // Result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [31:0]            m_axis_tdata,   // [15:0] angle, [31:16] turns
  output logic [1:0]             m_axis_tuser    // [0] updated, [1] rejected
);

  pwmenc_cmd_t        cmd;
  pwmenc_sts_t        sts;
  logic               busy;
  logic [ANGLE_W-1:0] out_angle;
  logic [TURN_W-1:0]  out_turns;
  logic               out_updated, out_rejected;

  // Registers are written whenever offered; the user keeps writes to idle periods
  assign cfg_ready_o = 1'b1;

  // Sequencer: accepts requests, walks width check, products, divide and commit
  pwmenc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  // Capture state, configuration, arithmetic and the result register
  pwmenc_dp #(
    .TIMER_BITS      (TIMER_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (s_axis_tuser),
    .ts_i           (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_angle_o    (out_angle),
    .out_turns_o    (out_turns),
    .out_updated_o  (out_updated),
    .out_rejected_o (out_rejected)
  );

  assign m_axis_tdata = {out_turns, out_angle};
  assign m_axis_tuser = {out_rejected, out_updated};

  // Every accepted request either yields a result at once or starts the sequence
  `PWMENC_ASSERT(a_accept_progress, (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid || busy), "accepted request neither answered nor in progress")
  // Hold off new requests while a computation runs
  `PWMENC_ASSERT_NEVER(a_no_accept_busy, busy && s_axis_tready, "request accepted while busy")
  // A result is never both an update and a rejection
  `PWMENC_ASSERT_NEVER(a_flags_excl, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "updated and rejected both set")

endmodule

`default_nettype wire

### dv/pwm_encoder_angle_tracker_unit_tb.sv
`default_nettype none

module pwm_encoder_angle_tracker_unit_tb;
  import pwmenc_pkg::*;

  // Codes the package leaves out: the fourth request kind and the unused register slot
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_NONE     = 2'd3;

  localparam int     ANGLE_FRAC   = 6;
  localparam longint HALF_TURN    = longint'(180) << ANGLE_FRAC;
  localparam longint TOP_ANGLE    = longint'(359) << ANGLE_FRAC;
  localparam int     DRAIN_CYCLES = 64;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam int     RANDOM_REQS  = 1950;
  localparam int     PHASE_REQS   = 200;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [TURN_W-1:0]  turns;
    logic                      updated;
    logic                      rejected;
  } report_t;

  // DUT connections, all inputs known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_tdata   = '0;   // [15:0] timestamp
  logic [1:0]        s_tuser   = '0;   // [1:0] kind
  logic              m_axis_tvalid;
  logic              m_tready  = 1'b0;
  logic [31:0]       m_axis_tdata;     // [15:0] angle, [31:16] turns
  logic [1:0]        m_axis_tuser;     // [0] updated, [1] rejected

  // Tracker shadow state
  logic [PERIOD_W-1:0]       period_reg;
  logic [DUTY_W-1:0]         low_reg;
  logic [DUTY_W-1:0]         high_reg;
  logic                      in_pulse;
  logic                      capture_held;
  logic [TS_W-1:0]           rise_ts;
  logic [TS_W-1:0]           fall_ts;
  logic [TALLY_W-1:0]        ovf_count;
  logic signed [ANGLE_W-1:0] angle_now;
  logic signed [TURN_W-1:0]  turns_now;

  report_t reports_q[$];
  int      err_cnt    = 0;
  int      cycle_cnt  = 0;
  int      hold_left  = 0;
  int      burst_left = 0;
  bit      gaps_on    = 1'b0;
  int      pulse_reqs = 0;

  pwm_encoder_angle_tracker_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Watchdog: stop a hung run
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tracker model
  // ---------------------------------------------------------------------------
  function automatic void reset_tracker();
    period_reg   = PERIOD_RST;
    low_reg      = LOW_RST;
    high_reg     = HIGH_RST;
    in_pulse     = 1'b0;
    capture_held = 1'b0;
    rise_ts      = '0;
    fall_ts      = '0;
    ovf_count    = '0;
    angle_now    = ANGLE_W'(HALF_TURN);
    turns_now    = TURN_RST;
  endfunction

  function automatic void write_register(logic [1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_PERIOD: period_reg = data[PERIOD_W-1:0];
      CFG_LOW:    low_reg    = data[DUTY_W-1:0];
      CFG_HIGH:   high_reg   = data[DUTY_W-1:0];
      default:    ;  // drop writes to the unused slot
    endcase
  endfunction

  // Round to nearest, halves away from zero; den is positive
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Turn the held capture into a new angle; 0 when the width is out of range
  function automatic bit convert_capture();
    logic [TS_W-1:0] diff;
    longint width, period, span, num, ang, jump;
    diff   = fall_ts - rise_ts;
    width  = longint'($signed(diff)) + longint'(ovf_count) * 65536;
    period = (period_reg == 0) ? 1 : longint'(period_reg);
    if (width < 0 || width > period) return 1'b0;
    span = longint'(high_reg) - longint'(low_reg) + 10;
    if (span < 1) span = 1;
    num = (width * 1000 - longint'(low_reg) * period) * 360 * (longint'(1) << ANGLE_FRAC);
    ang = TOP_ANGLE - round_div(num, period * span);
    if (ang > 32767) ang = 32767;
    if (ang < -32768) ang = -32768;
    // A jump of more than half a turn is a wraparound
    jump = ang - longint'(angle_now);
    if (jump > HALF_TURN) begin
      if (turns_now != $signed(TURN_MIN)) turns_now = turns_now - 16'sd1;
    end else if (jump < -HALF_TURN) begin
      if (turns_now != $signed(TURN_MAX)) turns_now = turns_now + 16'sd1;
    end
    angle_now = ANGLE_W'(ang);
    return 1'b1;
  endfunction

  // Advance the shadow state by one request and queue the report it causes
  function automatic void track_request(logic [1:0] kind, logic [15:0] ts);
    report_t rpt;
    rpt = '0;
    case (kind)
      KIND_EDGE: begin
        if (!capture_held) begin
          if (!in_pulse) begin
            rise_ts   = ts;
            ovf_count = '0;
            in_pulse  = 1'b1;
          end else begin
            fall_ts      = ts;
            in_pulse     = 1'b0;
            capture_held = 1'b1;
          end
        end
      end
      KIND_OVF: begin
        if (in_pulse && !capture_held && ovf_count != '1) ovf_count = ovf_count + 1'b1;
      end
      KIND_UPDATE: begin
        if (capture_held) begin
          capture_held = 1'b0;
          if (convert_capture()) rpt.updated = 1'b1;
          else rpt.rejected = 1'b1;
        end
      end
      default: ;  // unknown kind leaves the state alone
    endcase
    rpt.angle = angle_now;
    rpt.turns = turns_now;
    reports_q.push_back(rpt);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        // long hold-off requested by a test
        m_tready  <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 400);
        end
        mode_left = mode_left - 1;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_reports
    report_t exp_rpt;
    if (rst_n && m_axis_tvalid && m_tready) begin
      if (reports_q.size() == 0) begin
        $display("%0t: result with no request pending, actual angle %0d turns %0d flags %b",
                 $time, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                 m_axis_tuser);
        err_cnt = err_cnt + 1;
      end else begin
        exp_rpt = reports_q.pop_front();
        if (m_axis_tdata[15:0] !== exp_rpt.angle) begin
          $display("%0t: angle mismatch, expected %0d, actual %0d", $time,
                   exp_rpt.angle, $signed(m_axis_tdata[15:0]));
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tdata[31:16] !== exp_rpt.turns) begin
          $display("%0t: turns mismatch, expected %0d, actual %0d", $time,
                   exp_rpt.turns, $signed(m_axis_tdata[31:16]));
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tuser[0] !== exp_rpt.updated) begin
          $display("%0t: updated mismatch, expected %b, actual %b", $time,
                   exp_rpt.updated, m_axis_tuser[0]);
          err_cnt = err_cnt + 1;
        end
        if (m_axis_tuser[1] !== exp_rpt.rejected) begin
          $display("%0t: rejected mismatch, expected %b, actual %b", $time,
                   exp_rpt.rejected, m_axis_tuser[1]);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request and hold it until taken; tvalid stays high afterwards
  task automatic send_request(input logic [1:0] kind, input logic [15:0] ts);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= ts;
    do @(posedge clk); while (!s_axis_tready);
    track_request(kind, ts);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(posedge clk);
  endtask

  // Send with burst and gap shaping when enabled
  task automatic offer(input logic [1:0] kind, input logic [15:0] ts);
    send_request(kind, ts);
    pulse_reqs = pulse_reqs + 1;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left = burst_left - 1;
      end else begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
    end
  endtask

  // Drop tvalid, wait for every report, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a pulse width: mostly in range, plus limits, overshoot and negatives
  function automatic longint pick_width();
    longint p;
    p = (period_reg == 0) ? 1 : longint'(period_reg);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return p;
      2:       return p + $urandom_range(1, 64);
      3:       return -longint'($urandom_range(1, 200));
      4:       return (longint'(low_reg) * p) / 1000 + $urandom_range(0, 4) - 2;
      5:       return (longint'(high_reg) * p) / 1000 + $urandom_range(0, 4) - 2;
      default: return longint'($urandom_range(0, 32'(p)));
    endcase
  endfunction

  // One pulse: rise, overflows, fall, update; noisy pulses add stray requests
  task automatic send_pulse(input logic [15:0] rise, input longint width, input bit noisy);
    logic [15:0] fall;
    int          n_ovf;
    fall  = rise + width[15:0];
    n_ovf = (width > 32767) ? 1 : 0;
    offer(KIND_EDGE, rise);
    repeat (n_ovf) offer(KIND_OVF, 16'($urandom));
    if (noisy) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 2))
          0:       offer(KIND_OVF, 16'($urandom));
          1:       offer(KIND_UPDATE, 16'($urandom));
          default: offer(KIND_UNKNOWN, 16'($urandom));
        endcase
      end
    end
    offer(KIND_EDGE, fall);
    if (noisy && $urandom_range(0, 1)) begin
      // capture already held: these are ignored
      offer(KIND_EDGE, 16'($urandom));
      offer(KIND_OVF, 16'($urandom));
    end
    offer(KIND_UPDATE, 16'($urandom));
  endtask

  // Load one register setting; style walks the limits of each register
  task automatic load_setting(input int style);
    wait_idle();
    case (style)
      0: begin
        cfg_write(CFG_PERIOD, PERIOD_RST);
        cfg_write(CFG_LOW, CFG_W'(LOW_RST));
        cfg_write(CFG_HIGH, CFG_W'(HIGH_RST));
      end
      1: begin
        cfg_write(CFG_PERIOD, 16'hFFFF);
        cfg_write(CFG_LOW, 16'd0);
        cfg_write(CFG_HIGH, 16'd1000);
      end
      2: begin
        // span goes negative and is clamped to one: the angle can saturate
        cfg_write(CFG_PERIOD, 16'd1);
        cfg_write(CFG_LOW, 16'd1000);
        cfg_write(CFG_HIGH, 16'd0);
      end
      3: begin
        // period zero counts as one tick
        cfg_write(CFG_PERIOD, 16'd0);
        cfg_write(CFG_LOW, 16'($urandom_range(0, 1000)));
        cfg_write(CFG_HIGH, 16'($urandom_range(0, 1000)));
      end
      4: begin
        cfg_write(CFG_PERIOD, 16'($urandom_range(1, 2000)));
        cfg_write(CFG_LOW, 16'($urandom_range(0, 100)));
        cfg_write(CFG_HIGH, 16'($urandom_range(900, 1000)));
      end
      5: begin
        cfg_write(CFG_PERIOD, 16'($urandom_range(1, 65535)));
        cfg_write(CFG_LOW, 16'($urandom_range(500, 1000)));
        cfg_write(CFG_HIGH, 16'($urandom_range(0, 1000)));
      end
      6: begin
        // stray upper data bits and a write to the unused slot
        cfg_write(CFG_PERIOD, 16'($urandom_range(1, 65535)));
        cfg_write(CFG_LOW, {6'($urandom), 10'($urandom_range(0, 1000))});
        cfg_write(CFG_HIGH, {6'($urandom), 10'($urandom_range(0, 1000))});
        cfg_write(CFG_NONE, 16'($urandom));
      end
      default: begin
        cfg_write(CFG_PERIOD, 16'($urandom_range(1, 65535)));
        cfg_write(CFG_LOW, 16'($urandom_range(0, 1000)));
        cfg_write(CFG_HIGH, CFG_W'(low_reg));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Capture sequencing with reset registers: idle update, unknown kind, overflow
  // outside a pulse, wrapped timestamps, ignored edge and overflow while held
  task automatic test_capture_sequencing();
    gaps_on = 1'b0;
    send_request(KIND_UPDATE, 16'h0000);
    send_request(KIND_UNKNOWN, 16'hFFFF);
    send_request(KIND_OVF, 16'h1234);
    send_request(KIND_EDGE, 16'hFFFF);
    send_request(KIND_OVF, 16'h0000);
    send_request(KIND_EDGE, 16'h0225);
    send_request(KIND_EDGE, 16'h5555);
    send_request(KIND_OVF, 16'hAAAA);
    send_request(KIND_UPDATE, 16'hFFFF);
    wait_idle();
  endtask

  // Width at zero, at full scale, just over it, and negative
  task automatic test_width_limits();
    gaps_on = 1'b0;
    send_pulse(16'h0000, 0, 1'b0);
    send_pulse(16'hFFFF, longint'(PERIOD_RST), 1'b0);
    send_pulse(16'h8000, longint'(PERIOD_RST) + 1, 1'b0);
    send_pulse(16'h0064, -50, 1'b0);
    wait_idle();
  endtask

  // Hold the result side off while requests keep coming so the input stalls
  task automatic test_result_backpressure();
    gaps_on   = 1'b0;
    hold_left = 500;
    repeat (8) send_pulse(16'($urandom), pick_width(), 1'b0);
    wait_idle();
  endtask

  // Mostly well-formed pulses with random content, some noise, over several
  // register settings
  task automatic test_random_traffic();
    int phase;
    int phase_start;
    gaps_on    = 1'b1;
    phase      = 0;
    pulse_reqs = 0;
    while (pulse_reqs < RANDOM_REQS) begin
      load_setting(phase % 8);
      phase       = phase + 1;
      phase_start = pulse_reqs;
      while (pulse_reqs - phase_start < PHASE_REQS) begin
        if ($urandom_range(0, 99) < 80) begin
          send_pulse(16'($urandom), pick_width(), $urandom_range(0, 4) == 0);
        end else begin
          offer(2'($urandom_range(0, 3)), 16'($urandom));
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    reset_tracker();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    test_capture_sequencing();
    test_width_limits();
    test_result_backpressure();
    test_random_traffic();

    while (reports_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
